[rtl/lcs_pkg.sv]
// Package with the word types, command codes and cell control struct for the LCS length core.
`timescale 1ns / 1ps

package lcs_pkg;

  // Command codes carried in the input word.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  // Width of the length field in the result word.
  localparam int LEN_OUT_BITS = 7;

  // Input word: one symbol of either sequence.
  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
    logic       last;
  } lcs_in_t;

  // Result word: LCS length and the dropped-symbol flag.
  typedef struct packed {
    logic [LEN_OUT_BITS-1:0] lcs_length;
    logic                    overflow;
  } lcs_out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic adv;        // chain moves one step this cycle
    logic clear_row;  // a new first sequence starts: drop symbols and DP values
  } cell_ctrl_t;

endpackage

[rtl/lcs_length_core.sv]
// Top level of the LCS length core: load control, cell chain and result register.
//
// Usage: the input channel (in_valid, in_stall, in_word) carries one word per symbol.
// Load words (command 0) store the first sequence into the cells, one cell per word,
// up to MAX_LEN symbols; extra symbols are dropped and set the overflow flag. A load
// word after a compare or after a load marked last starts a new first sequence.
// Compare words (command 1) stream the second sequence into a chain of MAX_LEN cells;
// each word walks the chain one cell per cycle while the chain moves, so a compare word
// is accepted every cycle unless the chain is frozen. The compare word marked last yields
// one result word on the output channel (out_valid, out_stall, out_word) after it has
// passed every cell and the result register, and it clears the DP row behind it. A load
// word waits while compare words are still walking the chain.
// When out_stall holds a pending result, the whole chain freezes and compare words
// are stalled. Reset clears the DP row, the stored length and all flags; stored
// symbols hold no defined value until loaded.
`timescale 1ns / 1ps

module lcs_length_core import lcs_pkg::*; #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  lcs_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output lcs_out_t out_word
);

  localparam int SW = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = $clog2(MAX_LEN);

  logic          load_open;
  logic [LW-1:0] first_length;
  logic          dropped;
  logic [LW-1:0] busy;
  logic [LW-1:0] busy_next;

  logic          adv;
  logic          in_go;
  logic          load_go;
  logic          cmp_go;
  logic          has_room;
  logic [IW-1:0] wr_idx;
  logic [SW-1:0] in_sym;
  cell_ctrl_t    ctrl;
  logic [MAX_LEN-1:0] we;

  logic          tok_valid [MAX_LEN+1];
  logic          tok_last  [MAX_LEN+1];
  logic [SW-1:0] tok_sym   [MAX_LEN+1];
  logic [LW-1:0] tok_diag  [MAX_LEN+1];
  logic [LW-1:0] tok_above [MAX_LEN+1];

  logic               exit_result;
  logic [LW+LEN_OUT_BITS-1:0] len_wide;

  // Handshake: the chain moves unless a finished result is held; loads wait for an empty chain.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = (in_word.command == CMD_COMPARE) ? !adv : (busy != '0);
  assign in_go    = in_valid && !in_stall;
  assign load_go  = in_go && (in_word.command == CMD_LOAD);
  assign cmp_go   = in_go && (in_word.command == CMD_COMPARE);
  assign in_sym   = in_word.symbol[SW-1:0];

  // Write position for a load: a new sequence restarts at cell zero.
  assign has_room = !load_open || (first_length < LW'(MAX_LEN));
  assign wr_idx   = load_open ? first_length[IW-1:0] : '0;

  always_comb begin
    ctrl.adv       = adv;
    ctrl.clear_row = load_go && !load_open;
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_we
    assign we[k] = load_go && has_room && (wr_idx == IW'(k));
  end

  // Load bookkeeping: stored length, open load and dropped flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_open    <= 1'b0;
      first_length <= '0;
      dropped      <= 1'b0;
    end else if (load_go) begin
      load_open <= !in_word.last;
      if (!load_open) begin
        first_length <= LW'(1);
        dropped      <= 1'b0;
      end else if (has_room) begin
        first_length <= first_length + LW'(1);
      end else begin
        dropped <= 1'b1;
      end
    end else if (cmp_go) begin
      load_open <= 1'b0;
    end
  end

  // Count of compare words still walking the chain.
  always_comb begin
    busy_next = busy;
    if (cmp_go) begin
      busy_next = busy_next + LW'(1);
    end
    if (adv && tok_valid[MAX_LEN]) begin
      busy_next = busy_next - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= busy_next;
    end
  end

  // Token entering the chain head.
  assign tok_valid[0] = cmp_go;
  assign tok_last[0]  = in_word.last;
  assign tok_sym[0]   = in_sym;
  assign tok_diag[0]  = '0;
  assign tok_above[0] = '0;

  // The cell chain.
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lcs_cell #(
      .SW (SW),
      .LW (LW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .we            (we[k]),
      .load_sym      (in_sym),
      .tok_valid_in  (tok_valid[k]),
      .tok_last_in   (tok_last[k]),
      .tok_sym_in    (tok_sym[k]),
      .tok_diag_in   (tok_diag[k]),
      .tok_above_in  (tok_above[k]),
      .tok_valid_out (tok_valid[k+1]),
      .tok_last_out  (tok_last[k+1]),
      .tok_sym_out   (tok_sym[k+1]),
      .tok_diag_out  (tok_diag[k+1]),
      .tok_above_out (tok_above[k+1])
    );
  end

  // Result register: the last compare word leaving the chain carries the length.
  assign exit_result = tok_valid[MAX_LEN] && tok_last[MAX_LEN];
  assign len_wide    = {{LEN_OUT_BITS{1'b0}}, tok_above[MAX_LEN]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= exit_result;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && exit_result) begin
      out_word.lcs_length <= len_wide[LEN_OUT_BITS-1:0];
      out_word.overflow   <= dropped;
    end
  end

  // The in-flight count never exceeds the chain length.
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    busy <= LW'(MAX_LEN))
    else $error("in-flight count exceeds chain length");

  // A word leaving the chain was counted.
  a_exit_counted: assert property (@(posedge clk) disable iff (rst)
    tok_valid[MAX_LEN] |-> busy != '0)
    else $error("token left the chain without being counted");

  // A load that opens a new sequence leaves exactly one stored symbol.
  a_new_seq: assert property (@(posedge clk) disable iff (rst)
    (load_go && !load_open) |=> first_length == LW'(1))
    else $error("new first sequence did not restart at one symbol");

endmodule

[rtl/lcs_cell.sv]
// One cell of the systolic LCS chain: one stored symbol and its DP entry.
`timescale 1ns / 1ps

module lcs_cell import lcs_pkg::*; #(
  parameter int SW = 8,
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic          we,
  input  logic [SW-1:0] load_sym,
  input  logic          tok_valid_in,
  input  logic          tok_last_in,
  input  logic [SW-1:0] tok_sym_in,
  input  logic [LW-1:0] tok_diag_in,
  input  logic [LW-1:0] tok_above_in,
  output logic          tok_valid_out,
  output logic          tok_last_out,
  output logic [SW-1:0] tok_sym_out,
  output logic [LW-1:0] tok_diag_out,
  output logic [LW-1:0] tok_above_out
);

  logic [SW-1:0] stored;
  logic          used;
  logic [LW-1:0] dp;
  logic [LW-1:0] val;

  // DP update: a match extends the diagonal, otherwise take the larger neighbor.
  always_comb begin
    if (stored == tok_sym_in) begin
      val = tok_diag_in + LW'(1);
    end else if (dp > tok_above_in) begin
      val = dp;
    end else begin
      val = tok_above_in;
    end
  end

  // Control state: occupancy, DP entry and the token valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      dp            <= '0;
      tok_valid_out <= 1'b0;
    end else begin
      if (ctrl.clear_row) begin
        used <= we;
        dp   <= '0;
      end else begin
        if (we) begin
          used <= 1'b1;
        end
        if (ctrl.adv && used && tok_valid_in) begin
          // The last compare symbol leaves a cleared row behind it.
          dp <= tok_last_in ? '0 : val;
        end
      end
      if (ctrl.adv) begin
        tok_valid_out <= tok_valid_in;
      end
    end
  end

  // Payload: stored symbol and the token handed to the next cell.
  always_ff @(posedge clk) begin
    if (we) begin
      stored <= load_sym;
    end
    if (ctrl.adv) begin
      tok_last_out  <= tok_last_in;
      tok_sym_out   <= tok_sym_in;
      tok_diag_out  <= used ? dp  : tok_diag_in;
      tok_above_out <= used ? val : tok_above_in;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the LCS length core: stimulus, row predictor and result check.
`timescale 1ns / 1ps

module tb_top;
  import lcs_pkg::*;

  localparam int SEQ_CAP       = 64;
  localparam int ITEM_TOTAL    = 1200;
  localparam int MAX_GAP       = 12;
  localparam int LONG_HOLD     = 300;
  localparam int LONG_HOLD_AT  = 30;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PRINT_CAP     = 100;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lcs_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lcs_out_t out_word;

  lcs_length_core #(
    .MAX_LEN     (SEQ_CAP),
    .SYMBOL_BITS (8)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Words waiting to be sent and results waiting to arrive.
  lcs_in_t  word_backlog[$];
  lcs_out_t expected_results[$];
  int       errors = 0;

  // Predictor copy of the block state.
  logic [7:0]  seq_mem [SEQ_CAP];
  int          seq_len = 0;
  bit          loading = 1'b0;
  bit          dropped = 1'b0;
  int          dp_col [SEQ_CAP];

  // Sender and receiver pacing.
  int  send_gap = 0;
  bit  send_burst = 1'b0;
  int  out_hold_left = 0;
  bit  recv_burst = 1'b0;
  int  results_seen = 0;
  int  idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Store a load symbol or advance the DP row; queue the length when a second sequence ends.
  task automatic advance_lcs_row(input lcs_in_t w);
    int       diag;
    int       above;
    int       prev;
    lcs_out_t r;
    if (w.command == CMD_LOAD) begin
      if (!loading) begin
        seq_len = 0;
        dropped = 1'b0;
        foreach (dp_col[k]) dp_col[k] = 0;
      end
      if (seq_len < SEQ_CAP) begin
        seq_mem[seq_len] = w.symbol;
        seq_len++;
      end else begin
        dropped = 1'b1;
      end
      loading = !w.last;
    end else begin
      loading = 1'b0;
      diag = 0;
      above = 0;
      for (int k = 0; k < seq_len; k++) begin
        prev = dp_col[k];
        if (seq_mem[k] == w.symbol) dp_col[k] = diag + 1;
        else dp_col[k] = (prev > above) ? prev : above;
        diag = prev;
        above = dp_col[k];
      end
      if (w.last) begin
        r.lcs_length = (seq_len > 0) ? LEN_OUT_BITS'(dp_col[seq_len-1]) : '0;
        r.overflow = dropped;
        expected_results.push_back(r);
        foreach (dp_col[k]) dp_col[k] = 0;
      end
    end
  endtask

  task automatic push_word(input logic cmd, input logic [7:0] sym, input logic last);
    lcs_in_t w;
    w.command = cmd;
    w.symbol = sym;
    w.last = last;
    word_backlog.push_back(w);
  endtask

  // Symbols near a base value, so that matches are frequent when the span is narrow.
  function automatic logic [7:0] pick_sym(input logic [7:0] base, input int span);
    return base ^ 8'($urandom_range(0, span));
  endfunction

  task automatic push_run(input logic cmd, input int n, input logic [7:0] base,
                          input int span, input bit close);
    for (int k = 0; k < n; k++) push_word(cmd, pick_sym(base, span), close && (k == n - 1));
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int          roll;
    int          n;
    int          span;
    logic [7:0]  base;
    bit          have_seq;

    // Compare against an empty first sequence right after reset.
    push_word(CMD_COMPARE, 8'h5A, 1'b1);
    // Extreme symbol values in both sequences.
    push_word(CMD_LOAD, 8'h00, 1'b0);
    push_word(CMD_LOAD, 8'hFF, 1'b0);
    push_word(CMD_LOAD, 8'h80, 1'b0);
    push_word(CMD_LOAD, 8'h01, 1'b1);
    push_word(CMD_COMPARE, 8'hFF, 1'b0);
    push_word(CMD_COMPARE, 8'h01, 1'b1);
    // A lone last compare symbol counts as a one-symbol second sequence.
    push_word(CMD_COMPARE, 8'h00, 1'b1);
    push_word(CMD_COMPARE, 8'h80, 1'b0);
    push_word(CMD_COMPARE, 8'h00, 1'b0);
    push_word(CMD_COMPARE, 8'hFF, 1'b0);
    push_word(CMD_COMPARE, 8'h80, 1'b1);
    // A compare while a load is still open closes it.
    push_word(CMD_LOAD, 8'h7E, 1'b0);
    push_word(CMD_LOAD, 8'h81, 1'b0);
    push_word(CMD_COMPARE, 8'h81, 1'b1);
    push_word(CMD_LOAD, 8'h81, 1'b1);
    push_word(CMD_COMPARE, 8'h7E, 1'b0);
    push_word(CMD_COMPARE, 8'h81, 1'b1);
    push_word(CMD_COMPARE, 8'h42, 1'b1);

    // Full capacity with an identical second sequence gives the largest length.
    for (int k = 0; k < SEQ_CAP; k++) push_word(CMD_LOAD, 8'(k * 3 + 1), k == SEQ_CAP - 1);
    for (int k = 0; k < SEQ_CAP; k++) push_word(CMD_COMPARE, 8'(k * 3 + 1), k == SEQ_CAP - 1);
    // Too many load symbols, the last mark falling on a dropped one.
    push_run(CMD_LOAD, SEQ_CAP + 6, 8'h33, 1, 1'b1);
    push_run(CMD_COMPARE, 3, 8'h33, 1, 1'b1);
    // Too many load symbols with the load left open, closed by a compare.
    push_run(CMD_LOAD, SEQ_CAP + 2, 8'hC4, 3, 1'b0);
    push_run(CMD_COMPARE, 5, 8'hC4, 3, 1'b1);

    // Random part: mostly whole load/compare sequences, some loose noise words.
    have_seq = 1'b1;
    while (word_backlog.size() < ITEM_TOTAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        push_word(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        base = 8'($urandom);
        case ($urandom_range(0, 3))
          0: span = 0;
          1: span = 1;
          2: span = 3;
          default: span = 255;
        endcase
        if (roll < 45 || !have_seq) begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, SEQ_CAP + 8)
                                           : $urandom_range(1, 12);
          push_run(CMD_LOAD, n, base, span, 1'b1);
          have_seq = 1'b1;
        end
        repeat ($urandom_range(1, 3)) push_run(CMD_COMPARE, $urandom_range(1, 16),
                                               base, span, 1'b1);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (word_backlog.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SEQ_CAP + 20) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Sender: one word per handshake, with a random gap before each new word.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_lcs_row(in_word);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= word_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word, then hold off for a random number of cycles.
  always @(posedge clk) begin
    lcs_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: length %0d overflow %0b",
                                  out_word.lcs_length, out_word.overflow));
        end else begin
          want = expected_results.pop_front();
          if (out_word.lcs_length !== want.lcs_length)
            flag_mismatch($sformatf("lcs_length %0d, expected %0d",
                                    out_word.lcs_length, want.lcs_length));
          if (out_word.overflow !== want.overflow)
            flag_mismatch($sformatf("overflow %0b, expected %0b",
                                    out_word.overflow, want.overflow));
        end
        results_seen++;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        out_hold_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
        // One long hold-off so that the chain freezes and the input backs up.
        if (results_seen == LONG_HOLD_AT) out_hold_left = LONG_HOLD;
      end else if (out_hold_left > 0) begin
        out_hold_left--;
      end
      out_stall <= (out_hold_left > 0);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
rtl/lcs_pkg.sv
rtl/lcs_cell.sv
rtl/lcs_length_core.sv
dv/tb_top.sv
